// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BOH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BOH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/boh_pkg.sv =====
// Shared constants for the orbit density histogram core.
package boh_pkg;

  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;
  localparam int DEF_ORBIT_DEPTH = 2048;
  localparam int DEF_COUNT_BITS  = 32;

  localparam int SZ_W     = 9;
  localparam int LIM_W    = 12;
  localparam int CFG_DW   = 12;
  localparam int CFG_AW   = 3;
  localparam int PLOT_W   = 13;
  localparam int BIN_W    = 32;
  localparam int SAMPLE_W = 48;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RED    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GREEN  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BLUE   = 3'd4;

  localparam logic [SZ_W-1:0]  RST_WIDTH  = 9'd256;
  localparam logic [SZ_W-1:0]  RST_HEIGHT = 9'd256;
  localparam logic [LIM_W-1:0] RST_RED    = 12'd2000;
  localparam logic [LIM_W-1:0] RST_GREEN  = 12'd400;
  localparam logic [LIM_W-1:0] RST_BLUE   = 12'd80;

  // floor(t/13) = (t*COL_RECIP)>>COL_SHIFT, floor(t/15) likewise, exact for t < 2^16
  localparam logic [32:0] COL_RECIP = 33'd20165;
  localparam int          COL_SHIFT = 18;
  localparam logic [32:0] ROW_RECIP = 33'd69906;
  localparam int          ROW_SHIFT = 20;

  typedef logic signed [31:0] q28_t;

endpackage

// ===== rtl/core/buddhabrot_orbit_histogram_core.sv =====
// Orbit density histogram core: cardioid/bulb reject, 3-channel orbit iteration, bin counting.
// Sample: reject test (S_REJ1 to S_REJ4), then per channel an iteration loop (S_MUL, S_ADD) and, when
//   the orbit escapes, a plot pass over the kept points through the plot pipeline and its drain.
// Read bin: S_READ, then S_READ2. Clear: one bin per cycle (one write port), over every bin.
// Reset is synchronous; after reset the same clearing pass runs with busy high, no result.
// One item at a time; out_valid pulses for one cycle as busy drops.
module buddhabrot_orbit_histogram_core #(
  parameter int MAX_WIDTH   = boh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = boh_pkg::DEF_MAX_HEIGHT,
  parameter int ORBIT_DEPTH = boh_pkg::DEF_ORBIT_DEPTH,
  parameter int COUNT_BITS  = boh_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic signed [31:0]            in_c_real,
  input  logic signed [31:0]            in_c_imag,
  input  logic [7:0]                    in_bin_column,
  input  logic [7:0]                    in_bin_row,
  input  logic [1:0]                    in_bin_channel,
  output logic                          out_valid,
  output logic                          out_rejected,
  output logic [2:0]                    out_escaped_mask,
  output logic [boh_pkg::PLOT_W-1:0]    out_plotted_count,
  output logic [boh_pkg::BIN_W-1:0]     out_bin_value,
  output logic [boh_pkg::SAMPLE_W-1:0]  out_sample_count,
  input  logic                          cfg_we,
  input  logic [boh_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [boh_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int HIST_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3;
  localparam int HA_W = $clog2(HIST_DEPTH);
  localparam int OA_W = $clog2(ORBIT_DEPTH);
  localparam int N_W  = $clog2(ORBIT_DEPTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_REJ1  = 4'd2;
  localparam logic [3:0] S_REJ2  = 4'd3;
  localparam logic [3:0] S_REJ3  = 4'd4;
  localparam logic [3:0] S_REJ4  = 4'd5;
  localparam logic [3:0] S_CHAN  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_PLOT  = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;
  localparam logic [3:0] S_READ  = 4'd12;
  localparam logic [3:0] S_READ2 = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam logic [2:0] DRAIN_LAST = 3'd6;

  // configuration
  logic [boh_pkg::SZ_W-1:0]  width_r, height_r;
  logic [boh_pkg::LIM_W-1:0] lim_r [3];

  // control
  logic [3:0]      state_r;
  logic [HA_W-1:0] clr_cnt_r;
  logic            clr_reply_r;
  boh_pkg::q28_t   cre_r, cim_r;
  logic [7:0]      bcol_r, brow_r;
  logic [1:0]      bch_r, ch_r;
  logic [N_W-1:0]  n_r, k_r;
  logic [2:0]      drain_r;
  boh_pkg::q28_t   zr_r, zi_r;
  logic signed [63:0] pr_r, pi_r, px_r;
  logic signed [65:0] sq_a_r, sq_i_r, sq_b_r, rhs_r, lhs_r;
  logic signed [33:0] q_r;
  logic            bulb_r;

  // result
  logic                          out_valid_r, rej_r;
  logic [2:0]                    mask_r;
  logic [boh_pkg::PLOT_W-1:0]    plot_r;
  logic [boh_pkg::BIN_W-1:0]     binv_r;
  logic [boh_pkg::SAMPLE_W-1:0]  samples_r;

  // plot pipeline
  logic            p1_v_r, p2_v_r, p3_v_r, p4_v_r, wb_v_r;
  logic signed [20:0] tc_r, tr_r;
  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic [HA_W-1:0] p4_addr_r, wb_addr_r;
  logic [COUNT_BITS-1:0] wb_data_r;

  // memories
  logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [COUNT_BITS-1:0] hist_q_r;
  logic [63:0]           orbit_mem [ORBIT_DEPTH];
  logic [63:0]           orb_q_r;

  logic [boh_pkg::SZ_W-1:0] w_eff, h_eff;
  logic [N_W-1:0]  lim_eff;
  logic signed [32:0] a_s, b_s;
  logic            inr;
  logic [64:0]     mag;
  logic            esc_now;
  logic signed [65:0] nr, ni;
  boh_pkg::q28_t   zr_new, zi_new;
  logic            issue;
  boh_pkg::q28_t   oi_s, or_s;
  logic signed [39:0] bc, br;
  logic signed [49:0] xc, xr;
  logic [19:0]     tc_u, tr_u;
  logic            pt_ok;
  logic [32:0]     pc, prw;
  logic [HA_W-1:0] plot_addr, bin_addr;
  logic            bin_ok;
  logic [COUNT_BITS-1:0] cur_cnt, inc_cnt;
  logic            h_we;
  logic [HA_W-1:0] h_wa, h_ra;
  logic [COUNT_BITS-1:0] h_wd;

  function automatic boh_pkg::q28_t floor_sat(input logic signed [65:0] v);
    logic signed [37:0] s;
    boh_pkg::q28_t r;
    s = 38'(v >>> 28);
    if (s > 38'sd2147483647) r = 32'sh7FFFFFFF;
    else if (s < -38'sd2147483648) r = 32'sh80000000;
    else r = 32'(s);
    return r;
  endfunction

  // size registers: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (width_r == '0) w_eff = 9'd1;
    else if (int'(width_r) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = 9'd1;
    else if (int'(height_r) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
    else h_eff = height_r;
    if (int'(lim_r[ch_r]) > ORBIT_DEPTH) lim_eff = N_W'(ORBIT_DEPTH);
    else lim_eff = N_W'(lim_r[ch_r]);
  end

  // reject test operands
  assign a_s = 33'(cre_r) - 33'sd67108864;
  assign b_s = 33'(cre_r) + 33'sd268435456;
  assign inr = (cre_r > -32'sd402653184) && (cre_r < 32'sd402653184) &&
               (cim_r > -32'sd402653184) && (cim_r < 32'sd402653184);

  // iteration update
  assign mag     = {1'b0, pr_r} + {1'b0, pi_r};
  assign esc_now = mag > 65'd288230376151711744;
  assign nr      = 66'(pr_r) - 66'(pi_r) + (66'(cre_r) <<< 28);
  assign ni      = (66'(px_r) <<< 1) + (66'(cim_r) <<< 28);
  assign zr_new  = floor_sat(nr);
  assign zi_new  = floor_sat(ni);

  // screen mapping: column = floor(t/13), t = floor((10*im + 13*2^28)*w / 2^29)
  assign issue = (state_r == S_PLOT) && (k_r < n_r);
  assign or_s  = orb_q_r[63:32];
  assign oi_s  = orb_q_r[31:0];
  assign bc    = 40'(oi_s) * 40'sd10 + 40'sd3489660928;
  assign br    = 40'(or_s) * 40'sd10 + 40'sd5637144576;
  assign xc    = bc * $signed({1'b0, w_eff});
  assign xr    = br * $signed({1'b0, h_eff});
  assign tc_u  = tc_r[19:0];
  assign tr_u  = tr_r[19:0];
  assign pt_ok = !tc_r[20] && (tc_u < 20'(w_eff) * 20'd13) &&
                 !tr_r[20] && (tr_u < 20'(h_eff) * 20'd15);
  assign pc    = 33'(tc_u[15:0]) * boh_pkg::COL_RECIP;
  assign prw   = 33'(tr_u[15:0]) * boh_pkg::ROW_RECIP;

  assign plot_addr = HA_W'((int'(row_r) * MAX_WIDTH + int'(col_r)) * 3 + int'(ch_r));
  assign bin_addr  = HA_W'((int'(brow_r) * MAX_WIDTH + int'(bcol_r)) * 3 + int'(bch_r));
  assign bin_ok    = (int'(bcol_r) < MAX_WIDTH) && (int'(brow_r) < MAX_HEIGHT) &&
                     (bch_r != 2'd3);

  // forward the previous cycle's write: its read went out before that write landed
  assign cur_cnt = (wb_v_r && (wb_addr_r == p4_addr_r)) ? wb_data_r : hist_q_r;
  assign inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

  assign h_we = (state_r == S_CLR) || p4_v_r;
  assign h_wa = (state_r == S_CLR) ? clr_cnt_r : p4_addr_r;
  assign h_wd = (state_r == S_CLR) ? '0 : inc_cnt;
  assign h_ra = (state_r == S_READ) ? bin_addr : plot_addr;

  always_ff @(posedge clk) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    hist_q_r <= hist_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_ADD) && !esc_now) orbit_mem[n_r[OA_W-1:0]] <= {zr_new, zi_new};
    orb_q_r <= orbit_mem[k_r[OA_W-1:0]];
  end

  // plot pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r && pt_ok;
      p4_v_r <= p3_v_r;
      wb_v_r <= p4_v_r;
    end
    tc_r      <= 21'(xc >>> 29);
    tr_r      <= 21'(xr >>> 29);
    col_r     <= CW'(pc >> boh_pkg::COL_SHIFT);
    row_r     <= RW'(prw >> boh_pkg::ROW_SHIFT);
    p4_addr_r <= plot_addr;
    wb_addr_r <= p4_addr_r;
    wb_data_r <= inc_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      samples_r   <= '0;
      width_r     <= boh_pkg::RST_WIDTH;
      height_r    <= boh_pkg::RST_HEIGHT;
      lim_r[0]    <= boh_pkg::RST_RED;
      lim_r[1]    <= boh_pkg::RST_GREEN;
      lim_r[2]    <= boh_pkg::RST_BLUE;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          boh_pkg::REG_WIDTH:  width_r  <= cfg_data[boh_pkg::SZ_W-1:0];
          boh_pkg::REG_HEIGHT: height_r <= cfg_data[boh_pkg::SZ_W-1:0];
          boh_pkg::REG_RED:    lim_r[0] <= cfg_data;
          boh_pkg::REG_GREEN:  lim_r[1] <= cfg_data;
          boh_pkg::REG_BLUE:   lim_r[2] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == HA_W'(HIST_DEPTH - 1)) begin
            clr_cnt_r <= '0;
            state_r   <= clr_reply_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cre_r  <= in_c_real;
            cim_r  <= in_c_imag;
            bcol_r <= in_bin_column;
            brow_r <= in_bin_row;
            bch_r  <= in_bin_channel;
            rej_r  <= 1'b0;
            mask_r <= '0;
            plot_r <= '0;
            binv_r <= '0;
            unique case (in_kind)
              boh_pkg::KIND_SAMPLE: state_r <= S_REJ1;
              boh_pkg::KIND_READ:   state_r <= S_READ;
              boh_pkg::KIND_CLEAR: begin
                samples_r   <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLR;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_REJ1: begin
          sq_a_r  <= a_s * a_s;
          sq_i_r  <= cim_r * cim_r;
          sq_b_r  <= b_s * b_s;
          state_r <= S_REJ2;
        end
        S_REJ2: begin
          q_r     <= 34'((sq_a_r + sq_i_r) >>> 28);
          rhs_r   <= sq_i_r >>> 2;
          bulb_r  <= (sq_b_r + sq_i_r) <= 66'sd4503599627370496;
          state_r <= S_REJ3;
        end
        S_REJ3: begin
          lhs_r   <= q_r * (35'(q_r) + 35'(a_s));
          state_r <= S_REJ4;
        end
        S_REJ4: begin
          if (inr && ((lhs_r <= rhs_r) || bulb_r)) begin
            rej_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            ch_r    <= 2'd0;
            state_r <= S_CHAN;
          end
        end
        S_CHAN: begin
          n_r     <= '0;
          zr_r    <= '0;
          zi_r    <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          pr_r <= zr_r * zr_r;
          pi_r <= zi_r * zi_r;
          px_r <= zr_r * zi_r;
          state_r <= (n_r < lim_eff) ? S_ADD : S_NEXT;
        end
        S_ADD: begin
          if (esc_now) begin
            mask_r[ch_r] <= 1'b1;
            k_r          <= '0;
            state_r      <= S_PLOT;
          end else begin
            zr_r    <= zr_new;
            zi_r    <= zi_new;
            n_r     <= n_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_PLOT: begin
          if (issue) k_r <= k_r + 1'b1;
          else begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == DRAIN_LAST) state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (ch_r == 2'd2) begin
            if (!(&samples_r)) samples_r <= samples_r + 1'b1;
            state_r <= S_DONE;
          end else begin
            ch_r    <= ch_r + 1'b1;
            state_r <= S_CHAN;
          end
        end
        S_READ:  state_r <= S_READ2;
        S_READ2: begin
          if (bin_ok) binv_r <= 32'(hist_q_r);
          state_r <= S_DONE;
        end
        S_DONE: begin
          clr_reply_r <= 1'b0;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // per-sample plot count follows the pipeline, saturating
      if (p2_v_r && pt_ok && !(&plot_r)) plot_r <= plot_r + 1'b1;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_rejected      = rej_r;
  assign out_escaped_mask  = mask_r;
  assign out_plotted_count = plot_r;
  assign out_bin_value     = binv_r;
  assign out_sample_count  = samples_r;

endmodule

// ===== rtl/core/boh_checker.sv =====
// Port-level checks for the orbit histogram core, bound to the core module.
`include "assert_macros.svh"

module boh_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_rejected,
  input logic [2:0]                  out_escaped_mask,
  input logic [boh_pkg::PLOT_W-1:0]  out_plotted_count
);

  `BOH_ASSERT_NEXT(a_result_pulse, out_valid, !out_valid)
  `BOH_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `BOH_ASSERT_NOW(a_result_when_free, out_valid, !busy)
  `BOH_ASSERT_NOW(a_reject_clean, out_valid && out_rejected, out_escaped_mask == 3'd0 && out_plotted_count == '0)
  `BOH_ASSERT_NOW(a_plot_needs_escape, out_valid && out_escaped_mask == 3'd0, out_plotted_count == '0)

endmodule

bind buddhabrot_orbit_histogram_core boh_checker u_boh_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the orbit density histogram core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import boh_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [7:0]         bin_column;
    logic [7:0]         bin_row;
    logic [1:0]         bin_channel;
  } item_t;

  typedef struct {
    logic                rejected;
    logic [2:0]          escaped_mask;
    logic [PLOT_W-1:0]   plotted_count;
    logic [BIN_W-1:0]    bin_value;
    logic [SAMPLE_W-1:0] sample_count;
  } result_t;

  localparam int BINS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * 3;
  localparam longint ONE = 64'sd268435456;
  localparam longint SAMPLE_SAT = (64'd1 << 48) - 1;

  logic clk, rst_n, start, busy;
  logic [1:0] in_kind;
  logic signed [31:0] in_c_real, in_c_imag;
  logic [7:0] in_bin_column, in_bin_row;
  logic [1:0] in_bin_channel;
  logic out_valid, out_rejected;
  logic [2:0] out_escaped_mask;
  logic [PLOT_W-1:0] out_plotted_count;
  logic [BIN_W-1:0] out_bin_value;
  logic [SAMPLE_W-1:0] out_sample_count;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  buddhabrot_orbit_histogram_core dut (.*);

  // shadow state of the core
  logic [31:0] density_model [0:BINS-1];
  longint unsigned samples_seen;
  logic [SZ_W-1:0] width_reg, height_reg;
  logic [LIM_W-1:0] limit_reg [3];
  int hit_bins[$];

  result_t pending_results[$];
  int fails;
  int burst_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint sat32(wide_t x);
    if (x > wide_t'(64'sd2147483647)) return 64'sd2147483647;
    if (x < -wide_t'(64'sd2147483648)) return -64'sd2147483648;
    return longint'(x);
  endfunction

  function automatic bit in_body(longint cre, longint cim);
    longint lim, a, q, lhs, rhs, b;
    lim = 3 * (ONE / 2);
    if (cre <= -lim || cre >= lim || cim <= -lim || cim >= lim) return 0;
    a = cre - ONE / 4;
    q = (a * a + cim * cim) >>> 28;
    lhs = q * (q + a);
    rhs = (cim * cim) >>> 2;
    if (lhs <= rhs) return 1;
    b = cre + ONE;
    return (b * b + cim * cim) <= (64'sd1 <<< 52);
  endfunction

  // iterate one channel and bump its bins when the orbit escapes
  function automatic int trace_orbit(int ch, int lim, longint cre, longint cim, output bit esc);
    longint w, h, zr, zi, col, row;
    longint orb_r[$], orb_i[$];
    wide_t nr, ni;
    int n, plotted, idx;
    w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : height_reg);
    if (lim > DEF_ORBIT_DEPTH) lim = DEF_ORBIT_DEPTH;
    zr = 0; zi = 0; esc = 0; plotted = 0; n = 0;
    while (n < lim) begin
      if (wide_t'(zr) * zr + wide_t'(zi) * zi > (wide_t'(4) <<< 56)) begin
        esc = 1;
        break;
      end
      nr = wide_t'(zr) * zr - wide_t'(zi) * zi + (wide_t'(cre) <<< 28);
      ni = wide_t'(2) * zr * zi + (wide_t'(cim) <<< 28);
      zr = sat32(nr >>> 28);
      zi = sat32(ni >>> 28);
      orb_r.push_back(zr);
      orb_i.push_back(zi);
      n++;
    end
    if (!esc) return 0;
    foreach (orb_r[k]) begin
      col = floor_div((orb_i[k] * 10 + 13 * ONE) * w, 26 * ONE);
      row = floor_div((orb_r[k] * 10 + 21 * ONE) * h, 30 * ONE);
      if (col < 0 || row < 0 || col >= w || row >= h) continue;
      idx = int'((row * DEF_MAX_WIDTH + col) * 3 + ch);
      if (density_model[idx] != 32'hFFFF_FFFF) density_model[idx]++;
      if (hit_bins.size() < 400) hit_bins.push_back(idx);
      else hit_bins[$urandom_range(0, 399)] = idx;
      plotted++;
    end
    return plotted;
  endfunction

  function automatic result_t histogram_step(item_t it);
    result_t r;
    int total, idx;
    bit esc;
    r = '{default: '0};
    case (it.kind)
      KIND_SAMPLE: begin
        if (in_body(longint'(it.c_real), longint'(it.c_imag))) r.rejected = 1;
        else begin
          total = 0;
          for (int ch = 0; ch < 3; ch++) begin
            total += trace_orbit(ch, limit_reg[ch], it.c_real, it.c_imag, esc);
            r.escaped_mask[ch] = esc;
          end
          r.plotted_count = (total > 8191) ? 13'h1FFF : total[PLOT_W-1:0];
          if (samples_seen < SAMPLE_SAT) samples_seen++;
        end
      end
      KIND_READ: begin
        if (it.bin_channel != 2'd3) begin
          idx = (int'(it.bin_row) * DEF_MAX_WIDTH + int'(it.bin_column)) * 3 + it.bin_channel;
          r.bin_value = density_model[idx];
        end
      end
      KIND_CLEAR: begin
        foreach (density_model[i]) density_model[i] = '0;
        samples_seen = 0;
      end
      default: ;
    endcase
    r.sample_count = samples_seen[SAMPLE_W-1:0];
    return r;
  endfunction

  // must be called at a rising edge; returns at the edge that accepts the item, or after a random gap
  task automatic send_item(item_t it);
    in_kind <= it.kind;
    in_c_real <= it.c_real;
    in_c_imag <= it.c_imag;
    in_bin_column <= it.bin_column;
    in_bin_row <= it.bin_row;
    in_bin_channel <= it.bin_channel;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(histogram_step(it));
    // bursts with random gaps in between
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 6);
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = val[SZ_W-1:0];
      REG_HEIGHT: height_reg = val[SZ_W-1:0];
      REG_RED:    limit_reg[0] = val;
      REG_GREEN:  limit_reg[1] = val;
      REG_BLUE:   limit_reg[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_all(int w, int h, int r, int g, int b);
    write_reg(REG_WIDTH, CFG_DW'(w));
    write_reg(REG_HEIGHT, CFG_DW'(h));
    write_reg(REG_RED, CFG_DW'(r));
    write_reg(REG_GREEN, CFG_DW'(g));
    write_reg(REG_BLUE, CFG_DW'(b));
  endtask

  function automatic item_t make_sample(logic signed [31:0] re, logic signed [31:0] im);
    item_t it;
    it = '{default: '0};
    it.kind = KIND_SAMPLE;
    it.c_real = re;
    it.c_imag = im;
    return it;
  endfunction

  function automatic item_t make_read(int col, int row, int ch);
    item_t it;
    it = '{default: '0};
    it.kind = KIND_READ;
    it.bin_column = 8'(col);
    it.bin_row = 8'(row);
    it.bin_channel = 2'(ch);
    it.c_real = $urandom;
    it.c_imag = $urandom;
    return it;
  endfunction

  // point in the plotted window, mostly outside the set
  function automatic item_t window_sample();
    return make_sample($urandom_range(0, 724775732) - 563714458,
                       $urandom_range(0, 697932186) - 348966093);
  endfunction

  function automatic item_t read_hit_bin();
    int idx;
    if (hit_bins.size() == 0)
      return make_read($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3));
    idx = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
    return make_read((idx / 3) % DEF_MAX_WIDTH, idx / (3 * DEF_MAX_WIDTH), idx % 3);
  endfunction

  task automatic test_directed_edges();
    item_t it;
    send_item(make_sample(32'sd0, 32'sd0));                    // cardioid
    send_item(make_sample(-32'sd268435456, 32'sd0));           // period-2 bulb
    send_item(make_sample(32'sh8000_0000, 32'sh8000_0000));    // most negative
    send_item(make_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));    // most positive
    send_item(make_sample(32'sh0800_0000, 32'sh0800_0000));    // outside the set, escapes
    send_item(make_sample(32'sh04CC_CCCD, 32'sh0800_0000));
    send_item(make_sample(-32'sd402653183, 32'sd402653183));   // edge of test square
    send_item(read_hit_bin());
    send_item(read_hit_bin());
    send_item(make_read(255, 255, 2));
    send_item(make_read(0, 0, 0));
    send_item(make_read(17, 200, 3));                          // channel out of range
    it = make_read(5, 5, 1);
    it.kind = 2'd3;                                            // unused kind
    send_item(it);
    send_item(make_sample(32'sh0800_0000, -32'sh0800_0000));
    it = make_read(0, 0, 0);
    it.kind = KIND_CLEAR;
    send_item(it);
    send_item(read_hit_bin());
    send_item(make_sample(32'sh0600_0000, 32'sh0A00_0000));
  endtask

  task automatic test_size_and_limit_extremes();
    set_all(0, 0, 4095, 0, 1);       // sizes act as 1, red clamps to depth, green never escapes
    repeat (4) send_item(window_sample());
    send_item(read_hit_bin());
    set_all(1, 256, 2048, 1, 2048);
    repeat (4) send_item(window_sample());
    send_item(read_hit_bin());
    set_all(511, 300, 12, 3000, 7);  // sizes above max act as max
    repeat (6) send_item(window_sample());
    send_item(read_hit_bin());
  endtask

  task automatic test_random_mix(int count, int w, int h, int r, int g, int b);
    item_t it;
    int pick;
    set_all(w, h, r, g, b);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) it = window_sample();
      else if (pick < 62) it = make_sample($urandom, $urandom);
      else if (pick < 85) it = read_hit_bin();
      else if (pick < 95) it = make_read($urandom_range(0, 255), $urandom_range(0, 255),
                                         $urandom_range(0, 3));
      else begin
        it = make_read($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3));
        it.kind = 2'd3;
      end
      send_item(it);
    end
  endtask

  task automatic test_clear_midstream();
    item_t it;
    it = make_read(0, 0, 0);
    it.kind = KIND_CLEAR;
    send_item(it);
    repeat (6) send_item(window_sample());
    repeat (3) send_item(read_hit_bin());
  endtask

  // compare each result against the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_rejected !== e.rejected) begin
          $error("rejected: expected %0d got %0d", e.rejected, out_rejected);
          fails++;
        end
        if (out_escaped_mask !== e.escaped_mask) begin
          $error("escaped_mask: expected %0d got %0d", e.escaped_mask, out_escaped_mask);
          fails++;
        end
        if (out_plotted_count !== e.plotted_count) begin
          $error("plotted_count: expected %0d got %0d", e.plotted_count, out_plotted_count);
          fails++;
        end
        if (out_bin_value !== e.bin_value) begin
          $error("bin_value: expected %0d got %0d", e.bin_value, out_bin_value);
          fails++;
        end
        if (out_sample_count !== e.sample_count) begin
          $error("sample_count: expected %0d got %0d", e.sample_count, out_sample_count);
          fails++;
        end
      end
    end
  end

  initial begin
    #300_000_000;
    $display("[buddhabrot_orbit_histogram_core] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_c_real = '0;
    in_c_imag = '0;
    in_bin_column = '0;
    in_bin_row = '0;
    in_bin_channel = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fails = 0;
    burst_left = 0;
    foreach (density_model[i]) density_model[i] = '0;
    samples_seen = 0;
    width_reg = RST_WIDTH;
    height_reg = RST_HEIGHT;
    limit_reg[0] = RST_RED;
    limit_reg[1] = RST_GREEN;
    limit_reg[2] = RST_BLUE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_size_and_limit_extremes();
    test_random_mix(30, 256, 256, 150, 60, 20);
    test_clear_midstream();
    test_random_mix(25, 97, 13, 40, 300, 8);
    test_random_mix(20, 256, 256, 2000, 400, 80);

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("[buddhabrot_orbit_histogram_core] OK");
    else
      $display("[buddhabrot_orbit_histogram_core] ERROR");
    $finish;
  end

endmodule
